// File: design/kes_pkg.sv
package kes_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_EXTRACT = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO_KEY = 3'd1;
    localparam logic [2:0] ST_NO_KEY   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // One stored entry, key in the upper half.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

// File: design/keyed_entry_set.sv
// Sequence: insert, remove and lookup are accepted, then scan the stored
// entries (search, then move entries on remove), and give one result.
// Extract sorts the entries by key with an insertion sort, then emits N
// results for N entries.
// Throughput: one request at a time; the entry RAM read port sets the pace.
// Reset: synchronous active low; the count clears, the entry RAM is not reset.
module keyed_entry_set
    import kes_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: operation[1:0], key[33:2], value[65:34], zero fill to 72 bits
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: status[2:0], key_out[34:3], value_out[66:35], zero fill to 72 bits
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND_RD, S_FIND_CMP, S_DONE, S_SHIFT_RD, S_SHIFT_WR,
        S_SORT_RD, S_SORT_CMP, S_EMIT_RD, S_EMIT_WAIT, S_OUT
    } t_state;

    t_state        r_state;
    logic [1:0]    r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;      // scan index / outer sort index
    logic [CW-1:0] r_j;      // inner sort index
    t_entry        r_hold;   // entry being inserted during sort
    logic          r_outv;
    logic [2:0]    r_st;
    t_entry        r_oe;
    logic          r_olast;
    logic          r_emit;   // in emit phase of extract

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    kes_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // RAM port control from the sequencer state.
    always_comb begin
        we    = 1'b0;
        waddr = r_i[AW-1:0];
        wdata = rdata;
        raddr = r_i[AW-1:0];
        case (r_state)
            S_DONE: begin
                we    = (r_op == OP_INSERT) && (r_st == ST_OK);
                wdata = '{key: r_key, value: r_val};
            end
            S_SHIFT_RD: raddr = r_i[AW-1:0] + AW'(1);
            S_SHIFT_WR: we = 1'b1;
            S_SORT_RD:  raddr = r_j[AW-1:0] - AW'(1);
            S_SORT_CMP: begin
                we    = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = (r_j != '0 && rdata.key > r_hold.key) ? rdata : r_hold;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_outv;
    assign m_axis_tvalid = r_outv;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_oe.value, r_oe.key, r_st};

    // Sequencer and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_outv  <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            if (r_outv && m_axis_tready) r_outv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op  <= s_axis_tdata[1:0];
                        r_key <= s_axis_tdata[33:2];
                        r_val <= s_axis_tdata[65:34];
                        r_i   <= (s_axis_tdata[1:0] == OP_EXTRACT) ? CW'(1) : '0;
                        r_emit <= 1'b0;
                        if (s_axis_tdata[1:0] == OP_EXTRACT) begin
                            if (r_count == '0) begin
                                r_st <= ST_EMPTY; r_oe <= '0; r_olast <= 1'b1;
                                r_outv <= 1'b1;
                            end else begin
                                // Read entry one as the first entry to place.
                                r_state <= S_EMIT_WAIT;
                                r_j     <= CW'(1);
                            end
                        end else if (s_axis_tdata[1:0] == OP_INSERT &&
                                     s_axis_tdata[33:2] == '0) begin
                            r_st <= ST_ZERO_KEY; r_oe <= '0; r_olast <= 1'b1;
                            r_outv <= 1'b1;
                        end else begin
                            r_state <= S_FIND_RD;
                        end
                    end
                end
                S_FIND_RD: begin
                    if (r_i == r_count) begin
                        // Key absent.
                        r_olast <= 1'b1;
                        if (r_op != OP_INSERT) begin
                            r_st <= ST_NO_KEY; r_oe <= '0; r_outv <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            r_st <= ST_FULL; r_oe <= '0; r_outv <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_st <= ST_OK;
                            r_count <= r_count + CW'(1);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_FIND_CMP;
                    end
                end
                S_FIND_CMP: begin
                    if (rdata.key == r_key) begin
                        r_st <= ST_OK; r_olast <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_state <= S_FIND_RD;
                    end
                end
                S_DONE: begin
                    r_outv <= 1'b1;
                    if (r_op == OP_INSERT) begin
                        r_oe <= '{key: r_key, value: r_val};
                        r_state <= S_IDLE;
                    end else begin
                        r_oe <= rdata;
                        if (r_op == OP_REMOVE) begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_SHIFT_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    // r_count already reduced: move while r_i < new count.
                    if (r_i >= r_count) r_state <= S_IDLE;
                    else r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    r_i <= r_i + CW'(1);
                    r_state <= S_SHIFT_RD;
                end
                S_SORT_RD: begin
                    // Outer step start: finish the sort when no entry is left to place.
                    if (r_j == r_i) begin
                        if (r_i >= r_count) begin
                            r_i <= '0;
                            r_emit <= 1'b1;
                            r_state <= S_EMIT_RD;
                        end else begin
                            r_state <= S_SORT_CMP;
                        end
                    end else begin
                        r_state <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP: begin
                    // rdata holds entry j-1.
                    if (r_j != '0 && rdata.key > r_hold.key) begin
                        r_j <= r_j - CW'(1);
                        r_state <= S_SORT_RD;
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_j <= r_i + CW'(1);
                        r_state <= S_EMIT_WAIT;
                    end
                end
                S_EMIT_WAIT: begin
                    if (r_emit) begin
                        // Load the next result once the output register is empty.
                        if (!r_outv) begin
                            r_st <= ST_OK; r_oe <= rdata;
                            r_olast <= (r_i + CW'(1) == r_count);
                            r_outv <= 1'b1;
                            r_i <= r_i + CW'(1);
                            r_state <= (r_i + CW'(1) == r_count) ? S_IDLE : S_EMIT_RD;
                        end
                    end else begin
                        // Load next entry to insert: read at r_i issued now.
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_i >= r_count) begin
                        r_i <= '0;
                        r_emit <= 1'b1;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_hold  <= rdata;
                        r_state <= S_SORT_RD;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT_WAIT;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The entry count never exceeds the capacity.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count above capacity");
    // A request is taken only while idle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> r_state == S_IDLE)
        else $error("request taken while busy");
    // An offered result holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule

// File: design/kes_ram.sv
module kes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: tb/tb_keyed_entry_set.sv
`timescale 1ns / 100ps

module tb_keyed_entry_set
    import kes_pkg::*;
;

    localparam int CAP = 32;
    localparam int CYCLE_LIMIT = 2000000;

    // Expected result of one request or one extracted entry.
    typedef struct {
        logic [2:0]  status;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic        last;
    } t_result;

    // One directed stimulus row; has_exp marks rows with a typed-in result.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        bit          has_exp;
        logic [2:0]  exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    keyed_entry_set #(.CAPACITY(CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the table.
    logic [31:0] shadow_keys [CAP];
    logic [31:0] shadow_vals [CAP];
    int          shadow_count;

    t_result     pending_results [$];
    int          error_count;
    int          cycle_count;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          extract_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int find_entry(logic [31:0] key);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic t_result make_result(logic [2:0] st, logic [31:0] k,
                                            logic [31:0] v, logic l);
        t_result r;
        r.status = st;
        r.key_out = k;
        r.value_out = v;
        r.last = l;
        return r;
    endfunction

    // Update the shadow table for one request and queue the results it causes.
    task automatic predict_table(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        int          pos;
        int          j;
        logic [31:0] tk;
        logic [31:0] tv;
        case (op)
            OP_INSERT: begin
                pos = find_entry(key);
                if (key == 0) begin
                    pending_results.push_back(make_result(ST_ZERO_KEY, 0, 0, 1'b1));
                end else if (pos < 0 && shadow_count >= CAP) begin
                    pending_results.push_back(make_result(ST_FULL, 0, 0, 1'b1));
                end else begin
                    if (pos < 0) begin
                        pos = shadow_count;
                        shadow_count++;
                    end
                    shadow_keys[pos] = key;
                    shadow_vals[pos] = value;
                    pending_results.push_back(make_result(ST_OK, key, value, 1'b1));
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                pos = (key == 0) ? -1 : find_entry(key);
                if (pos < 0) begin
                    pending_results.push_back(make_result(ST_NO_KEY, 0, 0, 1'b1));
                end else begin
                    pending_results.push_back(make_result(ST_OK, shadow_keys[pos],
                                                          shadow_vals[pos], 1'b1));
                    if (op == OP_REMOVE) begin
                        for (int i = pos; i + 1 < shadow_count; i++) begin
                            shadow_keys[i] = shadow_keys[i + 1];
                            shadow_vals[i] = shadow_vals[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, 0, 0, 1'b1));
                end else begin
                    // Insertion sort leaves the table in ascending key order.
                    for (int i = 1; i < shadow_count; i++) begin
                        tk = shadow_keys[i];
                        tv = shadow_vals[i];
                        j = i;
                        while (j > 0 && shadow_keys[j - 1] > tk) begin
                            shadow_keys[j] = shadow_keys[j - 1];
                            shadow_vals[j] = shadow_vals[j - 1];
                            j--;
                        end
                        shadow_keys[j] = tk;
                        shadow_vals[j] = tv;
                    end
                    for (int i = 0; i < shadow_count; i++) begin
                        pending_results.push_back(make_result(ST_OK, shadow_keys[i],
                            shadow_vals[i], (i + 1 == shadow_count)));
                    end
                end
            end
        endcase
    endtask

    // Send one request, honoring the sender idle rate. Valid stays high after
    // the handshake so that a following request can go out back to back.
    task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, value, key, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_table(op, key, value);
        if (op == OP_EXTRACT) extract_count++;
    endtask

    // Receiver: random backpressure and in-order checking.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: tdata %h last %b", m_axis_tdata, m_axis_tlast);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[2:0] !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               m_axis_tdata[2:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[34:3] !== want.key_out) begin
                        $error("key_out: expected %h, actual %h", want.key_out,
                               m_axis_tdata[34:3]);
                        error_count++;
                    end
                    if (m_axis_tdata[66:35] !== want.value_out) begin
                        $error("value_out: expected %h, actual %h", want.value_out,
                               m_axis_tdata[66:35]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_keyed_entry_set failed");
            $finish;
        end
    end

    // Random key: mostly from a small pool so that hits are common.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(40, 1);
        endcase
    endfunction

    t_row rows [$];
    t_result want_row;
    int    phase;
    int    n;
    int    ops_in_phase;
    logic [1:0] rop;

    initial begin
        error_count = 0;
        cycle_count = 0;
        results_seen = 0;
        extract_count = 0;
        shadow_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty table, zero key, extremes and replace.
        rows.push_back('{OP_EXTRACT, 32'd0, 32'd0, 1'b1, ST_EMPTY});
        rows.push_back('{OP_LOOKUP, 32'd5, 32'd0, 1'b1, ST_NO_KEY});
        rows.push_back('{OP_REMOVE, 32'd0, 32'd0, 1'b1, ST_NO_KEY});
        rows.push_back('{OP_INSERT, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_ZERO_KEY});
        rows.push_back('{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_OK});
        rows.push_back('{OP_INSERT, 32'd1, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_INSERT, 32'h8000_0000, 32'h5555_AAAA, 1'b0, ST_OK});
        rows.push_back('{OP_INSERT, 32'd1, 32'hAAAA_5555, 1'b0, ST_OK});
        rows.push_back('{OP_LOOKUP, 32'd1, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_LOOKUP, 32'd0, 32'd0, 1'b1, ST_NO_KEY});
        rows.push_back('{OP_EXTRACT, 32'd0, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_REMOVE, 32'h8000_0000, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_REMOVE, 32'h8000_0000, 32'd0, 1'b1, ST_NO_KEY});
        rows.push_back('{OP_REMOVE, 32'd1, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_REMOVE, 32'hFFFF_FFFF, 32'd0, 1'b0, ST_OK});
        rows.push_back('{OP_EXTRACT, 32'd0, 32'd0, 1'b1, ST_EMPTY});
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                want_row = make_result(rows[i].exp_status, 0, 0, 1'b1);
                send_request(rows[i].op, rows[i].key, rows[i].value);
                if (pending_results[$].status !== want_row.status ||
                    pending_results[$].key_out !== want_row.key_out ||
                    pending_results[$].value_out !== want_row.value_out ||
                    pending_results[$].last !== want_row.last) begin
                    $error("status: expected %0d, actual %0d (predicted)",
                           rows[i].exp_status, pending_results[$].status);
                    error_count++;
                end
            end else begin
                send_request(rows[i].op, rows[i].key, rows[i].value);
            end
        end

        // Fill to capacity in descending order, overflow, replace, extract, then remove all.
        for (int k = CAP; k >= 1; k--) send_request(OP_INSERT, k * 3, $urandom);
        send_request(OP_INSERT, 32'd7, 32'd7);
        send_request(OP_INSERT, 32'd3, 32'hDEAD_BEEF);
        send_request(OP_EXTRACT, 32'd0, 32'd0);
        for (int k = 1; k <= CAP; k++) send_request(OP_REMOVE, k * 3, 32'd0);

        // Random phases with different idle patterns.
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 30 : 0;
            ops_in_phase = 80;
            for (n = 0; n < ops_in_phase; n++) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7: rop = OP_INSERT;
                    8, 9, 10, 11:           rop = OP_REMOVE;
                    12, 13, 14, 15, 16, 17: rop = OP_LOOKUP;
                    default:                rop = OP_EXTRACT;
                endcase
                send_request(rop, pick_key(), $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the block time to go quiet.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Covered %0d results, %0d extract requests, full and empty table cases.",
                 results_seen, extract_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_keyed_entry_set passed");
        end else begin
            $display("tb_keyed_entry_set failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/kes_pkg.sv
design/kes_ram.sv
design/keyed_entry_set.sv
tb/tb_keyed_entry_set.sv
